// ===== rtl/pps_pkg.sv =====
// Package for the preemptive priority scheduler: sizes, codes, sequencer
// states and the structs passed between the slot table and the top level.
// No dependencies.
`timescale 1ns / 1ps

package pps_pkg;

  localparam int NUM_SLOTS  = 8;
  localparam int SLOT_BITS  = $clog2(NUM_SLOTS);
  localparam int TIME_BITS  = 16;
  localparam int BURST_BITS = 8;
  localparam int PRIO_BITS  = 8;

  localparam logic [TIME_BITS-1:0] TIME_MAX  = {TIME_BITS{1'b1}};
  localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(NUM_SLOTS - 1);

  // input transaction kinds
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPD,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic [TIME_BITS-1:0]  arr;
    logic [PRIO_BITS-1:0]  prio;
    logic [BURST_BITS-1:0] orig;
    logic [BURST_BITS-1:0] rem;
    logic [TIME_BITS-1:0]  start;
    logic                  started;
  } entry_t;

  typedef struct packed {
    logic                  load;
    logic                  upd;
    logic [SLOT_BITS-1:0]  idx;
    logic [TIME_BITS-1:0]  arr;
    logic [BURST_BITS-1:0] burst;
    logic [PRIO_BITS-1:0]  prio;
    logic [BURST_BITS-1:0] rem;
    logic [TIME_BITS-1:0]  start;
  } tbl_wr_t;

endpackage

// ===== rtl/preemptive_priority_scheduler.sv =====
// Preemptive priority scheduler over eight job slots.
//
// Input channel (in_valid_i / in_ready_o): kind_i selects a load of one slot
// (slot_i, arrival_time_i, burst_length_i, priority_req_i) or one time tick.
// A load is written in the cycle it is accepted and gives no result.
// A tick scans the slots one per cycle through a single compare unit, then
// updates the winner (skipped when no slot is ready) and forms the result.
// The input is not ready while a tick is in progress.
// Output channel (out_valid_o / out_ready_i): one result per tick, held in an
// output register. The block takes the next transaction while a result waits;
// a following tick stalls in its last step until the output register is free.
// Reset clears the whole slot table, the time counter and both channels.
// Time saturates at its maximum value.
// Depends on pps_pkg, pps_table and pps_cmp.
`timescale 1ns / 1ps

module preemptive_priority_scheduler (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             kind_i,
  input  logic [2:0]                       slot_i,
  input  logic [15:0]                      arrival_time_i,
  input  logic [7:0]                       burst_length_i,
  input  logic [7:0]                       priority_req_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             idle_o,
  output logic [2:0]                       running_slot_o,
  output logic [15:0]                      tick_time_o,
  output logic                             finished_o,
  output logic [15:0]                      response_time_o,
  output logic [15:0]                      turnaround_time_o,
  output logic [15:0]                      waiting_time_o,
  output logic                             all_done_o
);

  pps_pkg::state_e state_q, state_d;

  logic [pps_pkg::SLOT_BITS-1:0]  idx_q;
  logic                           have_q;
  logic [pps_pkg::SLOT_BITS-1:0]  best_idx_q;
  logic [pps_pkg::PRIO_BITS-1:0]  best_prio_q;
  logic [pps_pkg::TIME_BITS-1:0]  best_arr_q;
  logic [pps_pkg::TIME_BITS-1:0]  now_q;
  logic                           fin_q;
  logic [pps_pkg::TIME_BITS-1:0]  resp_q;
  logic [pps_pkg::TIME_BITS-1:0]  tat_q;
  logic [pps_pkg::BURST_BITS-1:0] orig_q;
  logic                           out_valid_q;

  pps_pkg::tbl_wr_t               tbl_wr;
  logic [pps_pkg::SLOT_BITS-1:0]  rd_idx;
  pps_pkg::entry_t                rd_entry;
  logic [pps_pkg::NUM_SLOTS-1:0]  busy;
  logic                           take;
  logic                           accept;
  logic                           out_free;
  logic                           out_load;

  logic [pps_pkg::TIME_BITS-1:0]  start_used;
  logic [pps_pkg::BURST_BITS-1:0] rem_new;
  logic [pps_pkg::TIME_BITS-1:0]  comp_time;
  logic [pps_pkg::TIME_BITS-1:0]  orig_ext;
  logic [pps_pkg::TIME_BITS-1:0]  wait_val;

  pps_table u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (tbl_wr),
    .rd_idx_i (rd_idx),
    .rd_o     (rd_entry),
    .busy_o   (busy)
  );

  pps_cmp u_cmp (
    .cand_i      (rd_entry),
    .have_i      (have_q),
    .best_prio_i (best_prio_q),
    .best_arr_i  (best_arr_q),
    .now_i       (now_q),
    .take_o      (take)
  );

  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  // service arithmetic for the winning slot
  always_comb begin
    start_used = rd_entry.started ? rd_entry.start : now_q;
    rem_new    = rd_entry.rem - pps_pkg::BURST_BITS'(1);
    comp_time  = (now_q != pps_pkg::TIME_MAX) ? now_q + pps_pkg::TIME_BITS'(1) : now_q;
    orig_ext   = pps_pkg::TIME_BITS'(orig_q);
    wait_val   = (tat_q > orig_ext) ? tat_q - orig_ext : '0;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pps_pkg::ST_IDLE: begin
        if (accept && (kind_i == pps_pkg::KIND_TICK)) state_d = pps_pkg::ST_SCAN;
      end
      pps_pkg::ST_SCAN: begin
        if (idx_q == pps_pkg::LAST_SLOT) begin
          state_d = (have_q || take) ? pps_pkg::ST_UPD : pps_pkg::ST_FIN;
        end
      end
      pps_pkg::ST_UPD: begin
        state_d = pps_pkg::ST_FIN;
      end
      pps_pkg::ST_FIN: begin
        if (out_free) state_d = pps_pkg::ST_IDLE;
      end
      default: state_d = pps_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready_o   = 1'b0;
    out_load     = 1'b0;
    rd_idx       = idx_q;
    tbl_wr       = '0;
    tbl_wr.arr   = arrival_time_i;
    tbl_wr.burst = burst_length_i;
    tbl_wr.prio  = priority_req_i;
    tbl_wr.idx   = slot_i;
    unique case (state_q)
      pps_pkg::ST_IDLE: begin
        in_ready_o  = 1'b1;
        tbl_wr.load = accept && (kind_i == pps_pkg::KIND_LOAD);
      end
      pps_pkg::ST_SCAN: begin
        rd_idx = idx_q;
      end
      pps_pkg::ST_UPD: begin
        rd_idx       = best_idx_q;
        tbl_wr.upd   = 1'b1;
        tbl_wr.idx   = best_idx_q;
        tbl_wr.rem   = rem_new;
        tbl_wr.start = start_used;
      end
      pps_pkg::ST_FIN: begin
        out_load = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pps_pkg::ST_IDLE;
      now_q   <= '0;
      have_q  <= 1'b0;
      idx_q   <= '0;
      fin_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        pps_pkg::ST_IDLE: begin
          idx_q  <= '0;
          have_q <= 1'b0;
          fin_q  <= 1'b0;
        end
        pps_pkg::ST_SCAN: begin
          idx_q <= idx_q + pps_pkg::SLOT_BITS'(1);
          if (take) have_q <= 1'b1;
        end
        pps_pkg::ST_UPD: begin
          fin_q <= (rem_new == '0);
        end
        pps_pkg::ST_FIN: begin
          if (out_free && (now_q != pps_pkg::TIME_MAX)) begin
            now_q <= now_q + pps_pkg::TIME_BITS'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // candidate and finished-job payload
  always_ff @(posedge clk_i) begin
    if ((state_q == pps_pkg::ST_SCAN) && take) begin
      best_idx_q  <= idx_q;
      best_prio_q <= rd_entry.prio;
      best_arr_q  <= rd_entry.arr;
    end
    if (state_q == pps_pkg::ST_UPD) begin
      resp_q <= start_used - rd_entry.arr;
      tat_q  <= comp_time - rd_entry.arr;
      orig_q <= rd_entry.orig;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      idle_o            <= !have_q;
      running_slot_o    <= have_q ? best_idx_q : '0;
      tick_time_o       <= now_q;
      finished_o        <= fin_q;
      response_time_o   <= fin_q ? resp_q : '0;
      turnaround_time_o <= fin_q ? tat_q : '0;
      waiting_time_o    <= fin_q ? wait_val : '0;
      all_done_o        <= ~|busy;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/pps_table.sv =====
// Job slot table of the priority scheduler: one write port for loads and
// service updates, one read port, and a per-slot busy vector.
// Depends on pps_pkg.
`timescale 1ns / 1ps

module pps_table (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  pps_pkg::tbl_wr_t               wr_i,
  input  logic [pps_pkg::SLOT_BITS-1:0]  rd_idx_i,
  output pps_pkg::entry_t                rd_o,
  output logic [pps_pkg::NUM_SLOTS-1:0]  busy_o
);

  pps_pkg::entry_t tbl_q [pps_pkg::NUM_SLOTS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < pps_pkg::NUM_SLOTS; i++) begin
        tbl_q[i] <= '0;
      end
    end else if (wr_i.load) begin
      tbl_q[wr_i.idx].arr     <= wr_i.arr;
      tbl_q[wr_i.idx].prio    <= wr_i.prio;
      tbl_q[wr_i.idx].orig    <= wr_i.burst;
      tbl_q[wr_i.idx].rem     <= wr_i.burst;
      tbl_q[wr_i.idx].start   <= '0;
      tbl_q[wr_i.idx].started <= 1'b0;
    end else if (wr_i.upd) begin
      tbl_q[wr_i.idx].rem     <= wr_i.rem;
      tbl_q[wr_i.idx].start   <= wr_i.start;
      tbl_q[wr_i.idx].started <= 1'b1;
    end
  end

  assign rd_o = tbl_q[rd_idx_i];

  always_comb begin
    for (int i = 0; i < pps_pkg::NUM_SLOTS; i++) begin
      busy_o[i] = (tbl_q[i].rem != '0);
    end
  end

endmodule

// ===== rtl/pps_cmp.sv =====
// Shared compare unit of the scheduler: decides whether the slot under
// scan is ready and beats the best candidate found so far.
// Depends on pps_pkg.
`timescale 1ns / 1ps

module pps_cmp (
  input  pps_pkg::entry_t                 cand_i,
  input  logic                            have_i,
  input  logic [pps_pkg::PRIO_BITS-1:0]   best_prio_i,
  input  logic [pps_pkg::TIME_BITS-1:0]   best_arr_i,
  input  logic [pps_pkg::TIME_BITS-1:0]   now_i,
  output logic                            take_o
);

  logic ready;
  logic better;

  always_comb begin
    ready  = (cand_i.arr <= now_i) && (cand_i.rem != '0);
    // higher priority wins, then earlier arrival; lower slot kept on full tie
    better = !have_i || (cand_i.prio > best_prio_i) ||
             ((cand_i.prio == best_prio_i) && (cand_i.arr < best_arr_i));
    take_o = ready && better;
  end

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for preemptive_priority_scheduler: drives load and tick
// transactions with random gaps and output stalls, and checks each tick report.
// Depends on pps_pkg and the scheduler RTL.
`timescale 1ns / 1ps

module tb_top;

  localparam int CYCLE_LIMIT  = 400_000;
  localparam int RANDOM_ITEMS = 1900;

  typedef struct packed {
    logic        idle;
    logic [2:0]  running_slot;
    logic [15:0] tick_time;
    logic        finished;
    logic [15:0] response_time;
    logic [15:0] turnaround_time;
    logic [15:0] waiting_time;
    logic        all_done;
  } tick_report_t;

  class sched_scoreboard;
    logic [pps_pkg::TIME_BITS-1:0]  arr_tab   [pps_pkg::NUM_SLOTS];
    logic [pps_pkg::PRIO_BITS-1:0]  prio_tab  [pps_pkg::NUM_SLOTS];
    logic [pps_pkg::BURST_BITS-1:0] orig_tab  [pps_pkg::NUM_SLOTS];
    logic [pps_pkg::BURST_BITS-1:0] rem_tab   [pps_pkg::NUM_SLOTS];
    logic [pps_pkg::TIME_BITS-1:0]  start_tab [pps_pkg::NUM_SLOTS];
    bit                             started   [pps_pkg::NUM_SLOTS];
    logic [pps_pkg::TIME_BITS-1:0]  now_q;
    tick_report_t                   due_reports [$];
    int                             errors;

    function new();
      for (int s = 0; s < pps_pkg::NUM_SLOTS; s++) begin
        arr_tab[s]   = '0;
        prio_tab[s]  = '0;
        orig_tab[s]  = '0;
        rem_tab[s]   = '0;
        start_tab[s] = '0;
        started[s]   = 1'b0;
      end
      now_q  = '0;
      errors = 0;
    endfunction

    function int work_left();
      int total;
      total = 0;
      for (int s = 0; s < pps_pkg::NUM_SLOTS; s++) total += rem_tab[s];
      return total;
    endfunction

    // one scheduler tick: pick the winner, serve it and report
    function tick_report_t serve_tick();
      tick_report_t rep;
      int win;
      logic [pps_pkg::TIME_BITS-1:0] comp;
      logic [pps_pkg::TIME_BITS-1:0] tat;
      rep = '0;
      win = -1;
      rep.tick_time = now_q;
      for (int s = 0; s < pps_pkg::NUM_SLOTS; s++) begin
        if (arr_tab[s] <= now_q && rem_tab[s] != 0) begin
          if (win < 0 || prio_tab[s] > prio_tab[win] ||
              (prio_tab[s] == prio_tab[win] && arr_tab[s] < arr_tab[win]))
            win = s;
        end
      end
      if (win < 0) begin
        rep.idle = 1'b1;
      end else begin
        rep.running_slot = 3'(win);
        if (!started[win]) begin
          started[win]   = 1'b1;
          start_tab[win] = now_q;
        end
        rem_tab[win]--;
        if (rem_tab[win] == 0) begin
          comp = (now_q != pps_pkg::TIME_MAX) ? now_q + 1'b1 : pps_pkg::TIME_MAX;
          tat  = comp - arr_tab[win];
          rep.finished        = 1'b1;
          rep.response_time   = start_tab[win] - arr_tab[win];
          rep.turnaround_time = tat;
          rep.waiting_time    = (tat > orig_tab[win]) ? tat - orig_tab[win] : '0;
        end
      end
      rep.all_done = 1'b1;
      for (int s = 0; s < pps_pkg::NUM_SLOTS; s++)
        if (rem_tab[s] != 0) rep.all_done = 1'b0;
      if (now_q != pps_pkg::TIME_MAX) now_q++;
      return rep;
    endfunction

    function void note_transaction(logic kind, logic [2:0] slot, logic [15:0] arr,
                                   logic [7:0] burst, logic [7:0] prio);
      if (kind == pps_pkg::KIND_LOAD) begin
        if (slot < pps_pkg::NUM_SLOTS) begin
          arr_tab[slot]   = arr;
          prio_tab[slot]  = prio;
          orig_tab[slot]  = burst;
          rem_tab[slot]   = burst;
          start_tab[slot] = '0;
          started[slot]   = 1'b0;
        end
      end else begin
        due_reports.insert(due_reports.size(), serve_tick());
      end
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(tick_report_t got);
      tick_report_t want;
      if (due_reports.size() == 0) begin
        $error("tick report with no tick outstanding");
        errors++;
        return;
      end
      want = due_reports.pop_front();
      compare_field("idle", 16'(want.idle), 16'(got.idle));
      compare_field("running_slot", 16'(want.running_slot), 16'(got.running_slot));
      compare_field("tick_time", want.tick_time, got.tick_time);
      compare_field("finished", 16'(want.finished), 16'(got.finished));
      compare_field("response_time", want.response_time, got.response_time);
      compare_field("turnaround_time", want.turnaround_time, got.turnaround_time);
      compare_field("waiting_time", want.waiting_time, got.waiting_time);
      compare_field("all_done", 16'(want.all_done), 16'(got.all_done));
    endfunction
  endclass

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic        kind_i         = 1'b0;
  logic [2:0]  slot_i         = '0;
  logic [15:0] arrival_time_i = '0;
  logic [7:0]  burst_length_i = '0;
  logic [7:0]  priority_req_i = '0;
  logic        out_ready_i    = 1'b0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic        idle_o;
  logic [2:0]  running_slot_o;
  logic [15:0] tick_time_o;
  logic        finished_o;
  logic [15:0] response_time_o;
  logic [15:0] turnaround_time_o;
  logic [15:0] waiting_time_o;
  logic        all_done_o;

  tick_report_t    dut_report;
  sched_scoreboard sched;
  bit              allow_idle  = 1'b1;
  int              ready_hold  = 0;
  int              items_sent  = 0;
  int              cycle_count = 0;

  preemptive_priority_scheduler u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .kind_i            (kind_i),
    .slot_i            (slot_i),
    .arrival_time_i    (arrival_time_i),
    .burst_length_i    (burst_length_i),
    .priority_req_i    (priority_req_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .idle_o            (idle_o),
    .running_slot_o    (running_slot_o),
    .tick_time_o       (tick_time_o),
    .finished_o        (finished_o),
    .response_time_o   (response_time_o),
    .turnaround_time_o (turnaround_time_o),
    .waiting_time_o    (waiting_time_o),
    .all_done_o        (all_done_o)
  );

  assign dut_report = {idle_o, running_slot_o, tick_time_o, finished_o, response_time_o,
                       turnaround_time_o, waiting_time_o, all_done_o};

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // result side: check each accepted report, then choose next ready
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) sched.check_result(dut_report);
    if (ready_hold > 0) begin
      ready_hold  <= ready_hold - 1;
      out_ready_i <= 1'b0;
    end else if (allow_idle && $urandom_range(0, 5) == 0) begin
      ready_hold  <= $urandom_range(0, 3);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  task automatic send_item(input logic kind, input logic [2:0] slot,
                           input logic [15:0] arr, input logic [7:0] burst,
                           input logic [7:0] prio);
    if (allow_idle && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    kind_i         <= kind;
    slot_i         <= slot;
    arrival_time_i <= arr;
    burst_length_i <= burst;
    priority_req_i <= prio;
    do @(posedge clk_i); while (!in_ready_o);
    sched.note_transaction(kind, slot, arr, burst, prio);
    items_sent++;
  endtask

  task automatic load_job(input logic [2:0] slot, input logic [15:0] arr,
                          input logic [7:0] burst, input logic [7:0] prio);
    send_item(pps_pkg::KIND_LOAD, slot, arr, burst, prio);
  endtask

  // payload of a tick is ignored, so it carries noise
  task automatic tick_once();
    send_item(pps_pkg::KIND_TICK, 3'($urandom), 16'($urandom), 8'($urandom),
              8'($urandom));
  endtask

  function automatic logic [15:0] arrival_near();
    int t;
    t = int'(sched.now_q) + int'($urandom_range(0, 12)) - 4;
    if (t < 0) t = 0;
    if (t > int'(pps_pkg::TIME_MAX)) t = int'(pps_pkg::TIME_MAX);
    return 16'(t);
  endfunction

  task automatic random_job();
    logic [15:0] arr;
    logic [7:0]  burst;
    logic [7:0]  prio;
    int          pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) arr = 16'($urandom);
    else if (pick == 1) arr = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    else arr = arrival_near();
    pick = $urandom_range(0, 15);
    if (pick == 0) burst = 8'd0;
    else if (pick == 1) burst = 8'($urandom);
    else burst = 8'($urandom_range(1, 4));
    // narrow priorities give plenty of ties
    prio = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom);
    load_job(3'($urandom), arr, burst, prio);
  endtask

  initial begin
    sched = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tick_once();                          // empty table
    load_job(3'd0, 16'd0, 8'd0, 8'd255);  // zero burst never runs
    tick_once();
    load_job(3'd7, 16'd1, 8'd2, 8'd200);
    load_job(3'd2, 16'd1, 8'd1, 8'd200);  // same arrival as slot 7, lower slot first
    load_job(3'd4, 16'd0, 8'd1, 8'd200);  // earlier arrival wins the tie
    load_job(3'd1, 16'd4, 8'd255, 8'd255); // arrives later and preempts
    load_job(3'd5, 16'hFFFF, 8'd0, 8'd0);
    repeat (5) tick_once();
    load_job(3'd1, 16'd0, 8'd3, 8'd0);    // overwrite the running job
    repeat (6) tick_once();

    // episodes: a few loads, then a run of ticks with the odd load mixed in
    while (items_sent < RANDOM_ITEMS - 80) begin
      allow_idle = ($urandom_range(0, 2) != 0);
      repeat ($urandom_range(1, 5)) random_job();
      repeat ($urandom_range(1, 20)) begin
        if ($urandom_range(0, 9) == 0) random_job();
        else tick_once();
      end
    end

    // last stretch flat out, then refill every slot with short jobs and drain
    allow_idle = 1'b0;
    repeat (60) begin
      if ($urandom_range(0, 9) == 0) random_job();
      else tick_once();
    end
    for (int s = 0; s < pps_pkg::NUM_SLOTS; s++) begin
      load_job(3'(s), sched.now_q, 8'(s % 3), 8'(s));
    end
    while (sched.work_left() != 0) tick_once();
    repeat (5) tick_once();
    in_valid_i <= 1'b0;

    while (sched.due_reports.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (sched.errors == 0 && sched.due_reports.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
